### sv/hsv2rgb_pkg.sv
// Shared constants, types and helpers for the HSV to RGB converter.
package hsv2rgb_pkg;

  // Fixed-point formats
  localparam int HUE_FRAC_BITS  = 4;
  localparam int COMP_FRAC_BITS = 8;

  // Field widths
  localparam int HUE_W  = 13;
  localparam int COMP_W = 9;
  localparam int CHAN_W = 8;

  // Hue geometry: one sector is 60 degrees, one turn six sectors
  localparam int SECTOR_SPAN = 60 << HUE_FRAC_BITS;
  localparam int TURN        = 6 * SECTOR_SPAN;
  localparam int REM_W       = $clog2(SECTOR_SPAN);

  // Component one (1.0) and the full-scale term ONE * SECTOR_SPAN
  localparam int COMP_ONE = 1 << COMP_FRAC_BITS;
  localparam int ONE_SPAN = COMP_ONE * SECTOR_SPAN;
  localparam int TERM_W   = $clog2(ONE_SPAN + 1);

  // channel = floor(255 * v * term / (ONE * ONE * SPAN)).
  // SPAN = 15 << (HUE_FRAC_BITS + 2) and 255 = 15 * 17, so the division is
  // exact as a multiply by 17 and a right shift.
  localparam int CHAN_FACTOR = 255 / 15;
  localparam int CHAN_SHIFT  = 2 * COMP_FRAC_BITS + HUE_FRAC_BITS + 2;
  localparam int PROD_W      = COMP_W + TERM_W;
  localparam int SCALED_W    = PROD_W + $clog2(CHAN_FACTOR + 1);
  localparam int CHAN_MAX    = (1 << CHAN_W) - 1;

  typedef enum logic [2:0] {
    SECTOR_0,
    SECTOR_1,
    SECTOR_2,
    SECTOR_3,
    SECTOR_4,
    SECTOR_5
  } sector_t;

  // Stage 2 -> stage 3 payload
  typedef struct packed {
    sector_t             sector;
    logic [REM_W-1:0]    rem;
    logic [COMP_W-1:0]   sat;
    logic [COMP_W-1:0]   val;
  } split_t;

  // Stage 3 -> stage 4 payload: 1 - s*k terms scaled by ONE_SPAN
  typedef struct packed {
    sector_t             sector;
    logic [TERM_W-1:0]   term_p;
    logic [TERM_W-1:0]   term_q;
    logic [TERM_W-1:0]   term_t;
    logic [COMP_W-1:0]   val;
  } terms_t;

  // Start of a sector in hue units
  function automatic logic [HUE_W-1:0] sector_base(sector_t sec);
    return HUE_W'(32'(sec) * SECTOR_SPAN);
  endfunction

endpackage

### sv/hsv2rgb_hue_split.sv
// Stages 1-2: hue wrap, saturation clamp, sector and remainder split.
module hsv2rgb_hue_split (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [hsv2rgb_pkg::HUE_W-1:0]    in_hue,
  input  logic [hsv2rgb_pkg::COMP_W-1:0]   in_sat,
  input  logic [hsv2rgb_pkg::COMP_W-1:0]   in_val,
  output logic                             out_valid,
  input  logic                             out_ready,
  output hsv2rgb_pkg::split_t              out_data
);

  logic                             s1_valid_r;
  logic [hsv2rgb_pkg::HUE_W-1:0]    s1_hue_r;
  logic [hsv2rgb_pkg::COMP_W-1:0]   s1_sat_r;
  logic [hsv2rgb_pkg::COMP_W-1:0]   s1_val_r;
  logic [hsv2rgb_pkg::HUE_W-1:0]    s1_hue_nxt;
  logic [hsv2rgb_pkg::COMP_W-1:0]   s1_sat_nxt;
  logic                             s1_ready;

  logic                             s2_valid_r;
  hsv2rgb_pkg::split_t              s2_data_r;
  hsv2rgb_pkg::split_t              s2_data_nxt;
  logic                             s2_ready;

  assign s2_ready = !s2_valid_r || out_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;

  // Input range is below two turns, so one conditional subtract wraps it
  always_comb begin
    if (in_hue >= hsv2rgb_pkg::HUE_W'(hsv2rgb_pkg::TURN)) begin
      s1_hue_nxt = in_hue - hsv2rgb_pkg::HUE_W'(hsv2rgb_pkg::TURN);
    end else begin
      s1_hue_nxt = in_hue;
    end
    if (in_sat > hsv2rgb_pkg::COMP_W'(hsv2rgb_pkg::COMP_ONE)) begin
      s1_sat_nxt = hsv2rgb_pkg::COMP_W'(hsv2rgb_pkg::COMP_ONE);
    end else begin
      s1_sat_nxt = in_sat;
    end
  end

  // Sector by compare against the five sector boundaries
  always_comb begin
    hsv2rgb_pkg::sector_t sec;
    sec = hsv2rgb_pkg::SECTOR_0;
    for (int k = 1; k < 6; k++) begin
      if (s1_hue_r >= hsv2rgb_pkg::HUE_W'(k * hsv2rgb_pkg::SECTOR_SPAN)) begin
        sec = hsv2rgb_pkg::sector_t'(3'(k));
      end
    end
    s2_data_nxt.sector = sec;
    s2_data_nxt.rem    = hsv2rgb_pkg::REM_W'(s1_hue_r - hsv2rgb_pkg::sector_base(sec));
    s2_data_nxt.sat    = s1_sat_r;
    s2_data_nxt.val    = s1_val_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_r <= in_valid;
      if (s2_ready) s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_hue_r <= s1_hue_nxt;
      s1_sat_r <= s1_sat_nxt;
      s1_val_r <= in_val;
    end
    if (s2_ready) begin
      s2_data_r <= s2_data_nxt;
    end
  end

  assign out_valid = s2_valid_r;
  assign out_data  = s2_data_r;

  a_rem_in_sector: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> (32'(s2_data_r.rem) < hsv2rgb_pkg::SECTOR_SPAN))
    else $error("sector remainder out of range");

endmodule

### sv/hsv2rgb_terms.sv
// Stage 3: p, q and t terms (1 - s*k) in units of ONE * SECTOR_SPAN.
module hsv2rgb_terms (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  hsv2rgb_pkg::split_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output hsv2rgb_pkg::terms_t   out_data
);

  logic                              valid_r;
  hsv2rgb_pkg::terms_t               data_r;
  hsv2rgb_pkg::terms_t               data_nxt;
  logic [hsv2rgb_pkg::TERM_W-1:0]    span_sat;
  logic [hsv2rgb_pkg::TERM_W-1:0]    rem_sat;
  logic [hsv2rgb_pkg::TERM_W-1:0]    one_span;

  assign in_ready = !valid_r || out_ready;
  assign one_span = hsv2rgb_pkg::TERM_W'(hsv2rgb_pkg::ONE_SPAN);

  always_comb begin
    span_sat = hsv2rgb_pkg::TERM_W'(in_data.sat)
             * hsv2rgb_pkg::TERM_W'(hsv2rgb_pkg::SECTOR_SPAN);
    rem_sat  = hsv2rgb_pkg::TERM_W'(in_data.sat) * hsv2rgb_pkg::TERM_W'(in_data.rem);
    data_nxt.sector = in_data.sector;
    data_nxt.term_p = one_span - span_sat;
    data_nxt.term_q = one_span - rem_sat;
    data_nxt.term_t = one_span - span_sat + rem_sat;   // one_span - s*(SPAN - rem)
    data_nxt.val    = in_data.val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

  // q + t always sums to one plus p
  a_term_sum: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |->
      ((hsv2rgb_pkg::TERM_W+1)'(data_r.term_q) + (hsv2rgb_pkg::TERM_W+1)'(data_r.term_t)
       == (hsv2rgb_pkg::TERM_W+1)'(one_span) + (hsv2rgb_pkg::TERM_W+1)'(data_r.term_p)))
    else $error("p/q/t terms inconsistent");

endmodule

### sv/hsv2rgb_scale.sv
// Stages 4-5: value products, scale by 255, clamp and sector select.
module hsv2rgb_scale (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  hsv2rgb_pkg::terms_t              in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [hsv2rgb_pkg::CHAN_W-1:0]   out_red,
  output logic [hsv2rgb_pkg::CHAN_W-1:0]   out_green,
  output logic [hsv2rgb_pkg::CHAN_W-1:0]   out_blue
);

  localparam int PW = hsv2rgb_pkg::PROD_W;
  localparam int CW = hsv2rgb_pkg::CHAN_W;

  logic                    s4_valid_r;
  hsv2rgb_pkg::sector_t    s4_sector_r;
  logic [PW-1:0]           s4_mv_r;
  logic [PW-1:0]           s4_mp_r;
  logic [PW-1:0]           s4_mq_r;
  logic [PW-1:0]           s4_mt_r;
  logic                    s4_ready;

  logic                    s5_valid_r;
  logic [CW-1:0]           s5_red_r;
  logic [CW-1:0]           s5_green_r;
  logic [CW-1:0]           s5_blue_r;
  logic [CW-1:0]           s5_red_nxt;
  logic [CW-1:0]           s5_green_nxt;
  logic [CW-1:0]           s5_blue_nxt;
  logic [CW-1:0]           cv;
  logic [CW-1:0]           cp;
  logic [CW-1:0]           cq;
  logic [CW-1:0]           ct;
  logic                    s5_ready;

  // floor(prod * 17 >> shift), saturated to the channel range
  function automatic logic [CW-1:0] chan_of(logic [PW-1:0] prod);
    logic [hsv2rgb_pkg::SCALED_W-1:0] scaled;
    logic [hsv2rgb_pkg::SCALED_W-1:0] shifted;
    scaled  = hsv2rgb_pkg::SCALED_W'(prod)
            * hsv2rgb_pkg::SCALED_W'(hsv2rgb_pkg::CHAN_FACTOR);
    shifted = scaled >> hsv2rgb_pkg::CHAN_SHIFT;
    if (shifted > hsv2rgb_pkg::SCALED_W'(hsv2rgb_pkg::CHAN_MAX)) begin
      return CW'(hsv2rgb_pkg::CHAN_MAX);
    end
    return CW'(shifted);
  endfunction

  assign s5_ready = !s5_valid_r || out_ready;
  assign s4_ready = !s4_valid_r || s5_ready;
  assign in_ready = s4_ready;

  always_comb begin
    cv = chan_of(s4_mv_r);
    cp = chan_of(s4_mp_r);
    cq = chan_of(s4_mq_r);
    ct = chan_of(s4_mt_r);
    unique case (s4_sector_r)
      hsv2rgb_pkg::SECTOR_0: begin
        s5_red_nxt = cv; s5_green_nxt = ct; s5_blue_nxt = cp;
      end
      hsv2rgb_pkg::SECTOR_1: begin
        s5_red_nxt = cq; s5_green_nxt = cv; s5_blue_nxt = cp;
      end
      hsv2rgb_pkg::SECTOR_2: begin
        s5_red_nxt = cp; s5_green_nxt = cv; s5_blue_nxt = ct;
      end
      hsv2rgb_pkg::SECTOR_3: begin
        s5_red_nxt = cp; s5_green_nxt = cq; s5_blue_nxt = cv;
      end
      hsv2rgb_pkg::SECTOR_4: begin
        s5_red_nxt = ct; s5_green_nxt = cp; s5_blue_nxt = cv;
      end
      hsv2rgb_pkg::SECTOR_5: begin
        s5_red_nxt = cv; s5_green_nxt = cp; s5_blue_nxt = cq;
      end
      default: begin
        s5_red_nxt = cv; s5_green_nxt = cp; s5_blue_nxt = cq;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
    end else begin
      if (s4_ready) s4_valid_r <= in_valid;
      if (s5_ready) s5_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_ready) begin
      s4_sector_r <= in_data.sector;
      s4_mv_r     <= PW'(in_data.val) * PW'(hsv2rgb_pkg::ONE_SPAN);
      s4_mp_r     <= PW'(in_data.val) * PW'(in_data.term_p);
      s4_mq_r     <= PW'(in_data.val) * PW'(in_data.term_q);
      s4_mt_r     <= PW'(in_data.val) * PW'(in_data.term_t);
    end
    if (s5_ready) begin
      s5_red_r   <= s5_red_nxt;
      s5_green_r <= s5_green_nxt;
      s5_blue_r  <= s5_blue_nxt;
    end
  end

  assign out_valid = s5_valid_r;
  assign out_red   = s5_red_r;
  assign out_green = s5_green_r;
  assign out_blue  = s5_blue_r;

endmodule

### sv/hsv_to_rgb_converter_core.sv
// Top level of the HSV to RGB pixel converter.
//
// Usage:
//   in_*  channel carries one HSV pixel per transfer: hue in 1/16 degree
//         (5760 = 360 degrees, reduced modulo one turn), saturation Q1.8
//         (clamped to 1.0) and brightness Q1.8.
//   out_* channel carries one RGB pixel per transfer, each channel the
//         component times 255, truncated and saturated to 0..255.
//   Every input transfer yields exactly one output transfer, in order.
// Pipeline: an input pixel passes five register stages (hue wrap, sector
//   split, p/q/t terms, value multiply, scale/select) before out_tvalid
//   rises for it.
// Throughput: one pixel per clock while out_tready is high; every stage has its own
//   valid bit and holds unless it is empty or the next stage takes its content.
// Stall: when out_tready is low the last stage holds its pixel; earlier
//   stages keep filling bubbles, and in_tready drops only when all five
//   stages are occupied.
// Reset: synchronous, active low rst_n empties the pipeline; out_tvalid
//   is low in the cycle after reset.
module hsv_to_rgb_converter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [12:0] hue, [21:13] saturation, [30:22] brightness
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata    // [7:0] red, [15:8] green, [23:16] blue
);

  localparam int HW = hsv2rgb_pkg::HUE_W;
  localparam int CW = hsv2rgb_pkg::COMP_W;

  logic                             split_valid;
  logic                             split_ready;
  hsv2rgb_pkg::split_t              split_data;
  logic                             terms_valid;
  logic                             terms_ready;
  hsv2rgb_pkg::terms_t              terms_data;
  logic [hsv2rgb_pkg::CHAN_W-1:0]   red;
  logic [hsv2rgb_pkg::CHAN_W-1:0]   green;
  logic [hsv2rgb_pkg::CHAN_W-1:0]   blue;

  // Stages 1-2
  hsv2rgb_hue_split u_hue_split (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_hue    (in_tdata[HW-1:0]),
    .in_sat    (in_tdata[HW+CW-1:HW]),
    .in_val    (in_tdata[HW+2*CW-1:HW+CW]),
    .out_valid (split_valid),
    .out_ready (split_ready),
    .out_data  (split_data)
  );

  // Stage 3
  hsv2rgb_terms u_terms (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (split_valid),
    .in_ready  (split_ready),
    .in_data   (split_data),
    .out_valid (terms_valid),
    .out_ready (terms_ready),
    .out_data  (terms_data)
  );

  // Stages 4-5; stage 5 is the output register
  hsv2rgb_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (terms_valid),
    .in_ready  (terms_ready),
    .in_data   (terms_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_red   (red),
    .out_green (green),
    .out_blue  (blue)
  );

  assign out_tdata = {blue, green, red};

  // Input backpressure only when the output is full and stalled
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled while output side can drain");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule
